// ===== design/hhv_pkg.sv =====
package hhv_pkg;

  // longest host value that is scanned, in bytes
  localparam int unsigned MaxHostLen = 4096;
  // byte counters must hold the bound itself
  localparam int unsigned PosW = $clog2(MaxHostLen + 1);
  localparam int unsigned HostLenW = 13;

  localparam logic [7:0] ChDot      = 8'h2E;
  localparam logic [7:0] ChColon    = 8'h3A;
  localparam logic [7:0] ChLBracket = 8'h5B;
  localparam logic [7:0] ChRBracket = 8'h5D;
  localparam logic [7:0] ChNul      = 8'h00;
  localparam logic [7:0] ChSlash    = 8'h2F;
  localparam logic [7:0] ChUpperA   = 8'h41;
  localparam logic [7:0] ChUpperZ   = 8'h5A;

  typedef enum logic [1:0] {
    MODE_USUAL   = 2'd0,
    MODE_LITERAL = 2'd1,
    MODE_REST    = 2'd2
  } scan_mode_e;

  typedef struct packed {
    logic                needs_lowercase;
    logic [HostLenW-1:0] host_length;
    logic                verdict;
  } result_t;

endpackage

// ===== design/http_host_validator.sv =====
// http host value checker
// slave stream: one byte of the host header value per word in s_axis_tdata,
//   s_axis_tlast high on the final byte of the value
// master stream: one result word per value, sent after its last byte
//   (verdict, kept host length, lower-casing needed)
// a word accepted sits in the input register and is scanned from there; for a
//   last byte the result goes into the result register and shows on
//   m_axis_tvalid
// throughput is one byte per cycle unless a last byte waits for the result register;
//   the per-byte scan state update is a single compare-and-update step, so bytes flow back to back
// a rejected value still gives a result: verdict 1, length and flag zero
// reset clears the scan state and empties the input and result registers
// while the receiver stalls, the result is held; bytes that are not last keep
//   streaming in, and a last byte waits in the input register until the
//   result register frees up
module http_host_validator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic        s_axis_tlast,  // last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // [0] verdict, [13:1] host_length,
                                     // [14] needs_lowercase, [15] zero
);

  // input register
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // result register
  logic             out_valid_q, out_valid_d;
  hhv_pkg::result_t out_res_q;
  hhv_pkg::result_t scan_res;

  logic in_take;
  logic out_free;
  logic scan_fire;

  assign out_free      = !out_valid_q || m_axis_tready;
  // a last byte needs room for its result
  assign scan_fire     = in_valid_q && (!in_last_q || out_free);
  assign s_axis_tready = !in_valid_q || scan_fire;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  hhv_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (scan_fire),
    .data_byte_i (in_byte_q),
    .last_i      (in_last_q),
    .result_o    (scan_res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) in_valid_d = 1'b1;
    else if (scan_fire) in_valid_d = 1'b0;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (scan_fire && in_last_q) out_valid_d = 1'b1;
    else if (m_axis_tready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    if (scan_fire && in_last_q) out_res_q <= scan_res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_res_q.needs_lowercase, out_res_q.host_length,
                          out_res_q.verdict};

  // a rejected value reports no length and no lower-casing
  a_reject_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[14:1] == '0))
    else $error("rejected result carries length or flag");

  // a last byte never overwrites a result that is still waiting
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && in_last_q && out_valid_q && !m_axis_tready) |-> !scan_fire)
    else $error("result register overwritten while stalled");

  // a stalled byte in the input register blocks new words
  a_in_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !scan_fire) |-> !s_axis_tready)
    else $error("input register overrun");

  // every scanned last byte produces a visible result next cycle
  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (scan_fire && in_last_q) |=> m_axis_tvalid)
    else $error("result lost after last byte");

endmodule

// ===== design/hhv_scan.sv =====
module hhv_scan (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [7:0]       data_byte_i,
  input  logic             last_i,
  output hhv_pkg::result_t result_o
);

  hhv_pkg::scan_mode_e          mode_q, mode_d;
  logic [hhv_pkg::PosW-1:0]     pos_q, pos_d;
  logic [hhv_pkg::PosW-1:0]     last_dot_q, last_dot_d;
  logic                         dot_seen_q, dot_seen_d;
  logic [hhv_pkg::PosW-1:0]     host_end_q, host_end_d;
  logic                         host_end_set_q, host_end_set_d;
  logic                         rejected_q, rejected_d;
  logic                         upper_seen_q, upper_seen_d;

  // state after this byte, before the end-of-value clear
  hhv_pkg::scan_mode_e          mode_n;
  logic [hhv_pkg::PosW-1:0]     pos_n, last_dot_n, host_end_n;
  logic                         dot_seen_n, host_end_set_n, rejected_n, upper_seen_n;
  logic [hhv_pkg::PosW-1:0]     kept_len;
  logic                         reject_final;

  always_comb begin
    mode_n         = mode_q;
    pos_n          = pos_q;
    last_dot_n     = last_dot_q;
    dot_seen_n     = dot_seen_q;
    host_end_n     = host_end_q;
    host_end_set_n = host_end_set_q;
    rejected_n     = rejected_q;
    upper_seen_n   = upper_seen_q;
    if (!rejected_q) begin
      if (pos_q >= hhv_pkg::PosW'(hhv_pkg::MaxHostLen)) begin
        rejected_n = 1'b1;
      end else begin
        pos_n = pos_q + 1'b1;
        case (data_byte_i)
          hhv_pkg::ChDot: begin
            // double dot
            if (dot_seen_q && (pos_q != '0) && (last_dot_q == pos_q - 1'b1)) begin
              rejected_n = 1'b1;
              pos_n      = pos_q;
            end else begin
              dot_seen_n = 1'b1;
              last_dot_n = pos_q;
            end
          end
          hhv_pkg::ChColon: begin
            if (mode_q == hhv_pkg::MODE_USUAL) begin
              host_end_n     = pos_q;
              host_end_set_n = 1'b1;
              mode_n         = hhv_pkg::MODE_REST;
            end
          end
          hhv_pkg::ChLBracket: begin
            if (pos_q == '0) mode_n = hhv_pkg::MODE_LITERAL;
          end
          hhv_pkg::ChRBracket: begin
            if (mode_q == hhv_pkg::MODE_LITERAL) begin
              host_end_n     = pos_q + 1'b1;
              host_end_set_n = 1'b1;
              mode_n         = hhv_pkg::MODE_REST;
            end
          end
          hhv_pkg::ChNul, hhv_pkg::ChSlash: begin
            rejected_n = 1'b1;
            pos_n      = pos_q;
          end
          default: begin
            if (data_byte_i inside {[hhv_pkg::ChUpperA:hhv_pkg::ChUpperZ]}) begin
              upper_seen_n = 1'b1;
            end
          end
        endcase
      end
    end
  end

  // end-of-value length, one trailing dot trimmed
  always_comb begin
    kept_len = host_end_set_n ? host_end_n : pos_n;
    if (dot_seen_n && (kept_len != '0) && (last_dot_n == kept_len - 1'b1)) begin
      kept_len = kept_len - 1'b1;
    end
    reject_final = rejected_n || (kept_len == '0);
    result_o.verdict         = reject_final;
    result_o.host_length     = reject_final ? '0 : hhv_pkg::HostLenW'(kept_len);
    result_o.needs_lowercase = !reject_final && upper_seen_n;
  end

  always_comb begin
    mode_d         = mode_q;
    pos_d          = pos_q;
    last_dot_d     = last_dot_q;
    dot_seen_d     = dot_seen_q;
    host_end_d     = host_end_q;
    host_end_set_d = host_end_set_q;
    rejected_d     = rejected_q;
    upper_seen_d   = upper_seen_q;
    if (fire_i) begin
      if (last_i) begin
        mode_d         = hhv_pkg::MODE_USUAL;
        pos_d          = '0;
        last_dot_d     = '0;
        dot_seen_d     = 1'b0;
        host_end_d     = '0;
        host_end_set_d = 1'b0;
        rejected_d     = 1'b0;
        upper_seen_d   = 1'b0;
      end else begin
        mode_d         = mode_n;
        pos_d          = pos_n;
        last_dot_d     = last_dot_n;
        dot_seen_d     = dot_seen_n;
        host_end_d     = host_end_n;
        host_end_set_d = host_end_set_n;
        rejected_d     = rejected_n;
        upper_seen_d   = upper_seen_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= hhv_pkg::MODE_USUAL;
      pos_q          <= '0;
      last_dot_q     <= '0;
      dot_seen_q     <= 1'b0;
      host_end_q     <= '0;
      host_end_set_q <= 1'b0;
      rejected_q     <= 1'b0;
      upper_seen_q   <= 1'b0;
    end else begin
      mode_q         <= mode_d;
      pos_q          <= pos_d;
      last_dot_q     <= last_dot_d;
      dot_seen_q     <= dot_seen_d;
      host_end_q     <= host_end_d;
      host_end_set_q <= host_end_set_d;
      rejected_q     <= rejected_d;
      upper_seen_q   <= upper_seen_d;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  // watchdog: cycles with no word moving on either side before giving up
  localparam int unsigned IdleLimit = 2000;
  // long receiver hold-off, started after this many results
  localparam int unsigned HoldAfter = 40;
  localparam int unsigned HoldCycles = 300;
  // random part size, in bytes
  localparam int unsigned RandomBytes = 1000;
  // spare cycles at the end, after the last result is checked
  localparam int unsigned TailCycles = 10;

  // one queued input word plus a flag that makes the sender wait for all results
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       drain;
  } host_byte_t;

  // scan state kept by the predictor
  typedef struct {
    hhv_pkg::scan_mode_e      mode;
    logic [hhv_pkg::PosW-1:0] pos;
    logic [hhv_pkg::PosW-1:0] dot_pos;
    logic [hhv_pkg::PosW-1:0] end_pos;
    logic                     dot_seen;
    logic                     end_set;
    logic                     bad;
    logic                     upper;
  } host_scan_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] data_byte
  logic        s_axis_tlast = 1'b0; // last
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [0] verdict, [13:1] host_length,
                                    // [14] needs_lowercase, [15] zero

  host_byte_t       byte_q[$];           // words waiting to be sent
  logic [7:0]       value_buf[$];        // host value under construction
  hhv_pkg::result_t host_results_q[$];   // verdicts still to arrive, oldest first
  host_scan_t       scan;

  int unsigned error_count = 0;
  int unsigned send_gap = 0;
  bit          send_burst = 1'b0;
  int unsigned recv_gap = 0;
  bit          recv_burst = 1'b0;
  int unsigned results_seen = 0;
  int unsigned idle_cycles = 0;
  int unsigned directed_bytes;

  http_host_validator u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  task automatic clear_scan();
    scan.mode     = hhv_pkg::MODE_USUAL;
    scan.pos      = '0;
    scan.dot_pos  = '0;
    scan.end_pos  = '0;
    scan.dot_seen = 1'b0;
    scan.end_set  = 1'b0;
    scan.bad      = 1'b0;
    scan.upper    = 1'b0;
  endtask

  // one byte of a value that is not yet rejected
  task automatic scan_host_byte(input logic [7:0] b);
    // too long: any byte past the bound rejects
    if (scan.pos >= hhv_pkg::MaxHostLen) begin
      scan.bad = 1'b1;
      return;
    end
    case (b)
      hhv_pkg::ChDot: begin
        // dot right after a dot, host or port part alike
        if (scan.dot_seen && scan.pos != 0 && scan.dot_pos == scan.pos - 1'b1) begin
          scan.bad = 1'b1;
          return;
        end
        scan.dot_seen = 1'b1;
        scan.dot_pos  = scan.pos;
      end
      hhv_pkg::ChColon: begin
        if (scan.mode == hhv_pkg::MODE_USUAL) begin
          scan.end_pos = scan.pos;
          scan.end_set = 1'b1;
          scan.mode    = hhv_pkg::MODE_REST;
        end
      end
      hhv_pkg::ChLBracket: begin
        // literal only when the bracket opens the value
        if (scan.pos == 0) scan.mode = hhv_pkg::MODE_LITERAL;
      end
      hhv_pkg::ChRBracket: begin
        if (scan.mode == hhv_pkg::MODE_LITERAL) begin
          scan.end_pos = scan.pos + 1'b1;
          scan.end_set = 1'b1;
          scan.mode    = hhv_pkg::MODE_REST;
        end
      end
      hhv_pkg::ChNul, hhv_pkg::ChSlash: begin
        scan.bad = 1'b1;
        return;
      end
      default: begin
        // upper case counts anywhere, port part too
        if (b >= hhv_pkg::ChUpperA && b <= hhv_pkg::ChUpperZ) scan.upper = 1'b1;
      end
    endcase
    scan.pos = scan.pos + 1'b1;
  endtask

  // called for every accepted input word; queues a verdict on the last byte
  task automatic predict_byte(input logic [7:0] b, input logic is_last);
    logic [hhv_pkg::PosW-1:0] hl;
    hhv_pkg::result_t         r;
    if (!scan.bad) scan_host_byte(b);
    if (is_last) begin
      hl = scan.end_set ? scan.end_pos : scan.pos;
      // one trailing dot trimmed, judged only by the last dot seen
      if (scan.dot_seen && hl != 0 && scan.dot_pos == hl - 1'b1) hl = hl - 1'b1;
      if (hl == 0) scan.bad = 1'b1;
      r.verdict = scan.bad;
      r.host_length = scan.bad ? '0 : hhv_pkg::HostLenW'(hl);
      r.needs_lowercase = scan.bad ? 1'b0 : scan.upper;
      host_results_q.push_back(r);
      clear_scan();
    end
  endtask

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("tb_top: mismatch on %s: got %0d, want %0d, at %0t", what, got, want, $time);
    error_count++;
  endtask

  task automatic check_result(input logic [15:0] word);
    hhv_pkg::result_t got;
    hhv_pkg::result_t want;
    got = hhv_pkg::result_t'(word[14:0]);
    if (host_results_q.size() == 0) begin
      report_mismatch("unexpected result word", 32'(word), 0);
      return;
    end
    want = host_results_q.pop_front();
    if (got.verdict !== want.verdict)
      report_mismatch("verdict", 32'(got.verdict), 32'(want.verdict));
    if (got.host_length !== want.host_length)
      report_mismatch("host_length", 32'(got.host_length), 32'(want.host_length));
    if (got.needs_lowercase !== want.needs_lowercase)
      report_mismatch("needs_lowercase", 32'(got.needs_lowercase),
                      32'(want.needs_lowercase));
  endtask

  // ---------------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------------

  task automatic add_text(input string s);
    for (int k = 0; k < s.len(); k++) value_buf.push_back(s[k]);
  endtask

  // move the built value into the send queue, tlast on its final byte
  task automatic commit_value(input bit drain);
    host_byte_t w;
    for (int k = 0; k < value_buf.size(); k++) begin
      w.data  = value_buf[k];
      w.last  = (k == value_buf.size() - 1);
      w.drain = drain && (k == 0);
      byte_q.push_back(w);
    end
    value_buf.delete();
  endtask

  task automatic add_random_chars(input string pool, input int unsigned n);
    for (int unsigned k = 0; k < n; k++)
      value_buf.push_back(pool[$urandom_range(0, pool.len() - 1)]);
  endtask

  task automatic add_port();
    value_buf.push_back(hhv_pkg::ChColon);
    add_random_chars("0123456789", $urandom_range(1, 5));
  endtask

  task automatic insert_byte(input logic [7:0] b);
    int unsigned at;
    at = $urandom_range(0, value_buf.size());
    if (at == value_buf.size()) value_buf.push_back(b);
    else value_buf.insert(at, b);
  endtask

  // mostly well-formed names and literals, some noise and broken values
  task automatic queue_random_host();
    int unsigned kind;
    int unsigned labels;
    int unsigned flaw;
    string       label_chars;
    label_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-";
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      // raw noise over the whole byte range
      for (int unsigned k = $urandom_range(1, 12); k > 0; k--)
        value_buf.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 25) begin
      // bracketed ipv6 literal, sometimes unclosed, often with a port
      value_buf.push_back(hhv_pkg::ChLBracket);
      add_random_chars("0123456789abcdefABCDEF:", $urandom_range(1, 14));
      if ($urandom_range(0, 9) != 0) value_buf.push_back(hhv_pkg::ChRBracket);
      if ($urandom_range(0, 1) != 0) add_port();
    end else if (kind < 27) begin
      // rare longer name
      add_random_chars(label_chars, $urandom_range(200, 600));
    end else begin
      // dns name of a few labels
      labels = $urandom_range(1, 4);
      for (int unsigned k = 0; k < labels; k++) begin
        if (k != 0) value_buf.push_back(hhv_pkg::ChDot);
        add_random_chars(label_chars, $urandom_range(1, 8));
      end
      if ($urandom_range(0, 4) == 0) value_buf.push_back(hhv_pkg::ChDot);
      if ($urandom_range(0, 9) < 4) add_port();
      if ($urandom_range(0, 19) == 0) value_buf.push_back(hhv_pkg::ChDot);
    end
    // corrupt some values
    if ($urandom_range(0, 99) < 15) begin
      flaw = $urandom_range(0, 3);
      case (flaw)
        0: insert_byte(hhv_pkg::ChNul);
        1: insert_byte(hhv_pkg::ChSlash);
        2: begin
          insert_byte(hhv_pkg::ChDot);
          insert_byte(hhv_pkg::ChDot);
        end
        default: insert_byte(8'($urandom_range(0, 255)));
      endcase
    end
    commit_value($urandom_range(0, 19) == 0);
  endtask

  // ---------------------------------------------------------------------------
  // sender: one word per handshake, random gaps, optional wait for all results
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
      send_gap = 0;
      clear_scan();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_byte(s_axis_tdata, s_axis_tlast);
        // switch between idling and back-to-back stretches now and then
        if ($urandom_range(0, 63) == 0) send_burst = !send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, 8);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (byte_q.size() != 0 &&
                     (!byte_q[0].drain || host_results_q.size() == 0)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= byte_q[0].data;
          s_axis_tlast  <= byte_q[0].last;
          void'(byte_q.pop_front());
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: checks each result word, random stalls and one long hold-off
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_gap = 0;
      results_seen = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_result(m_axis_tdata);
        results_seen++;
        if ($urandom_range(0, 63) == 0) recv_burst = !recv_burst;
        if (results_seen == HoldAfter) recv_gap = HoldCycles;
        else recv_gap = recv_burst ? 0 : $urandom_range(0, 8);
      end
      if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles where no word moves
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("tb_top: done, errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------

  initial begin
    // directed values
    add_text("a");                   commit_value(1'b0);
    add_text(".");                   commit_value(1'b0); // trims to empty
    add_text("Example.COM.");        commit_value(1'b0); // trailing dot, upper case
    add_text("a..b");                commit_value(1'b0); // double dot
    add_text("ab"); value_buf.push_back(hhv_pkg::ChNul); add_text("c");
    commit_value(1'b0);                                  // nul byte
    add_text("a/b");                 commit_value(1'b0); // slash
    add_text("[::1]:8080");          commit_value(1'b0); // literal with port
    add_text("[FE80::1]");           commit_value(1'b0); // literal, upper hex
    add_text("a[b]");                commit_value(1'b0); // brackets not leading
    add_text("host:80:90");          commit_value(1'b0); // colon in port part
    add_text("h:PORT");              commit_value(1'b0); // upper case in port
    add_text("a.:80");               commit_value(1'b0); // dot before the port
    add_text("ab:8.0.");             commit_value(1'b0); // dot ending the port
    add_text("a:1..2");              commit_value(1'b0); // double dot in port
    add_text(":80");                 commit_value(1'b0); // empty host
    add_text("[]");                  commit_value(1'b0);
    add_text("[");                   commit_value(1'b0); // unclosed literal
    value_buf.push_back(8'h01); value_buf.push_back(8'h7F);
    value_buf.push_back(8'h80); value_buf.push_back(8'hFF);
    commit_value(1'b0);                                  // byte extremes
    add_text("@AZ[`z");              commit_value(1'b0); // letter range edges
    add_text("Z");                   commit_value(1'b1);
    directed_bytes = byte_q.size();

    while (byte_q.size() < directed_bytes + RandomBytes) queue_random_host();

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (byte_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (host_results_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== http_host_validator.f =====
design/hhv_pkg.sv
design/hhv_scan.sv
design/http_host_validator.sv
tb/tb_top.sv
